// ----- hdl/tca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_pkg: touch calibration solver package
// Shared types, codes, and matrix helper functions for the affine solver.
// ----------------------------------------------------------------------------
package tca_pkg;

	localparam int MAX_POINTS = 10;
	localparam int MIN_POINTS = 4;
	localparam int COORD_W = 12;
	localparam int CNT_W = 5;
	localparam int LIN_W = 16;
	localparam int PRD_W = 32;
	localparam int COEF_W = 64;
	localparam int ACC_W = 100;
	localparam int DIV_W = 128;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_SOLVE = 2'd2;

	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_FEW = 3'd2;
	localparam logic [2:0] ST_SINGULAR = 3'd3;
	localparam logic [2:0] ST_SOLVED = 3'd4;

	localparam int LS_X = 0;
	localparam int LS_Y = 1;
	localparam int LS_SX = 2;
	localparam int LS_SY = 3;
	localparam int PS_XX = 0;
	localparam int PS_XY = 1;
	localparam int PS_YY = 2;
	localparam int PS_SXX = 3;
	localparam int PS_SXY = 4;
	localparam int PS_SYX = 5;
	localparam int PS_SYY = 6;

	localparam int NUM_TERMS = 6;
	localparam int NUM_DETS = 7;

	// Column used in rows 0, 1 and 2 for each of the six determinant terms.
	localparam logic [NUM_TERMS-1:0][1:0] TERM_C0 = {2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0};
	localparam logic [NUM_TERMS-1:0][1:0] TERM_C1 = {2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1};
	localparam logic [NUM_TERMS-1:0][1:0] TERM_C2 = {2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2};
	localparam logic [2:0] FIRST_NEG_TERM = 3'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_DET,
		S_DETEND,
		S_DIV,
		S_STORE
	} state_t;

	typedef struct packed {
		logic [3:0][LIN_W-1:0] lin;
		logic [6:0][PRD_W-1:0] prd;
	} sums_t;

	// Entry (r, c) of the matrix for determinant d: d = 0 is the base
	// matrix, d = 1..3 and 4..6 replace column d-1 or d-4 by the right side.
	function automatic logic [PRD_W-1:0] elem(input sums_t s, input logic [CNT_W-1:0] cnt,
			input logic [2:0] d, input logic [1:0] r, input logic [1:0] c);
		logic [PRD_W-1:0] v;
		logic [1:0] k;
		logic sys2;
		logic repl;
		v = '0;
		k = 2'd0;
		sys2 = 1'b0;
		repl = 1'b1;
		case (d)
			3'd1: begin k = 2'd0; end
			3'd2: begin k = 2'd1; end
			3'd3: begin k = 2'd2; end
			3'd4: begin k = 2'd0; sys2 = 1'b1; end
			3'd5: begin k = 2'd1; sys2 = 1'b1; end
			3'd6: begin k = 2'd2; sys2 = 1'b1; end
			default: begin repl = 1'b0; end
		endcase
		if (repl && c == k) begin
			case (r)
				2'd0: v = sys2 ? s.prd[PS_SYX] : s.prd[PS_SXX];
				2'd1: v = sys2 ? s.prd[PS_SYY] : s.prd[PS_SXY];
				default: v = PRD_W'(sys2 ? s.lin[LS_SY] : s.lin[LS_SX]);
			endcase
		end else begin
			case ({r, c})
				4'b0000: v = s.prd[PS_XX];
				4'b0001, 4'b0100: v = s.prd[PS_XY];
				4'b0010, 4'b1000: v = PRD_W'(s.lin[LS_X]);
				4'b0101: v = s.prd[PS_YY];
				4'b0110, 4'b1001: v = PRD_W'(s.lin[LS_Y]);
				4'b1010: v = PRD_W'(cnt);
				default: v = '0;
			endcase
		end
		return v;
	endfunction

	function automatic logic [COEF_W-1:0] sat_q32(input logic [DIV_W-1:0] q, input logic neg);
		logic [COEF_W-1:0] v;
		if (neg) begin
			if (q[DIV_W-1:COEF_W] != '0 || q[COEF_W-1:0] > {1'b1, {(COEF_W-1){1'b0}}})
				v = {1'b1, {(COEF_W-1){1'b0}}};
			else
				v = COEF_W'(0) - q[COEF_W-1:0];
		end else begin
			if (q[DIV_W-1:COEF_W] != '0 || q[COEF_W-1] != 1'b0)
				v = {1'b0, {(COEF_W-1){1'b1}}};
			else
				v = q[COEF_W-1:0];
		end
		return v;
	endfunction

endpackage

// ----- hdl/tca_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_if: touch calibration channels
// Request channel carrying calibration items and response channel carrying
// status and coefficients, both with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tca_req_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [tca_pkg::COORD_W-1:0] touch_x;
	logic [tca_pkg::COORD_W-1:0] touch_y;
	logic [tca_pkg::COORD_W-1:0] screen_x;
	logic [tca_pkg::COORD_W-1:0] screen_y;
	modport source (output valid, opcode, touch_x, touch_y, screen_x, screen_y, input ready);
	modport sink (input valid, opcode, touch_x, touch_y, screen_x, screen_y, output ready);
endinterface

interface tca_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic signed [tca_pkg::COEF_W-1:0] coef_a;
	logic signed [tca_pkg::COEF_W-1:0] coef_b;
	logic signed [tca_pkg::COEF_W-1:0] coef_c;
	logic signed [tca_pkg::COEF_W-1:0] coef_d;
	logic signed [tca_pkg::COEF_W-1:0] coef_e;
	logic signed [tca_pkg::COEF_W-1:0] coef_f;
	modport source (output valid, status, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
		input ready);
	modport sink (input valid, status, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
		output ready);
endinterface

// ----- hdl/touch_calibration_affine_solver_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_calibration_affine_solver_core: least-squares touch calibration
// Collects calibration points in running sums and solves the affine map
// from touch to screen coordinates exactly, giving Q31.32 coefficients.
// ----------------------------------------------------------------------------
// Usage: each item on req clears the points, adds one point, or solves.
// Every item gives exactly one item on rsp with a status and six
// coefficients, which are zero unless the status is solved.
// Clear, refused adds and solves with too few points answer in the cycle after acceptance.
// An accepted add sends the seven products one per cycle through the
// single 32x32 multiplier.
// A solve computes 7 determinants of 6 terms each on the multiplier, plus 6
// restoring divisions in the bit-serial divider, which does most of the work.
// A singular system answers after the first determinant.
// One item is in work at a time: req.ready is low from acceptance until the
// result has been taken on rsp, so a stalled receiver holds off the next
// item and the result stays stable.
// Reset clears the point count and all sums and drops any pending result.
// ----------------------------------------------------------------------------
module touch_calibration_affine_solver_core (
	input logic clk,
	input logic arst_n,
	tca_req_if.sink req,
	tca_rsp_if.source rsp
);

	tca_pkg::state_t state_q, state_d;
	tca_pkg::sums_t sums_q;
	logic [tca_pkg::CNT_W-1:0] cnt_q;

	logic [tca_pkg::COORD_W-1:0] tx_q, ty_q, sx_q, sy_q;
	logic [2:0] add_idx_q;
	logic [2:0] det_q;
	logic [2:0] term_q;
	logic [1:0] ph_q;
	logic [6:0] div_cnt_q;

	logic [63:0] prod_q;
	logic [31:0] thi_q;
	logic [tca_pkg::ACC_W-1:0] acc_q;
	logic [tca_pkg::ACC_W-1:0] dmag_q;
	logic dneg_q;
	logic nneg_q;
	logic [tca_pkg::DIV_W-1:0] rem_q, quo_q, dvd_q;

	logic out_valid_q;
	logic [2:0] status_q;
	logic [tca_pkg::COEF_W-1:0] coef_q [tca_pkg::NUM_TERMS];

	logic accept;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [tca_pkg::ACC_W-1:0] acc_mag;
	logic [tca_pkg::DIV_W-1:0] den, rsh;
	logic ge;
	logic neg_term;
	logic add_last, term_last, div_last;

	assign accept = req.valid && req.ready;
	assign mul_p = mul_a * mul_b;
	assign acc_mag = acc_q[tca_pkg::ACC_W-1] ? (tca_pkg::ACC_W'(0) - acc_q) : acc_q;
	assign den = tca_pkg::DIV_W'(dmag_q);
	assign rsh = {rem_q[tca_pkg::DIV_W-2:0], dvd_q[tca_pkg::DIV_W-1]};
	assign ge = rsh >= den;
	assign neg_term = term_q >= tca_pkg::FIRST_NEG_TERM;
	assign add_last = add_idx_q == 3'd6;
	assign term_last = (term_q == 3'(tca_pkg::NUM_TERMS - 1)) && (ph_q == 2'd3);
	assign div_last = div_cnt_q == 7'(tca_pkg::DIV_W - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tca_pkg::S_IDLE: begin
				if (accept) begin
					if (req.opcode == tca_pkg::OP_ADD && cnt_q < tca_pkg::CNT_W'(tca_pkg::MAX_POINTS))
						state_d = tca_pkg::S_ADD;
					else if (req.opcode == tca_pkg::OP_SOLVE
							&& cnt_q >= tca_pkg::CNT_W'(tca_pkg::MIN_POINTS))
						state_d = tca_pkg::S_DET;
				end
			end
			tca_pkg::S_ADD: begin
				if (add_last)
					state_d = tca_pkg::S_IDLE;
			end
			tca_pkg::S_DET: begin
				if (term_last)
					state_d = tca_pkg::S_DETEND;
			end
			tca_pkg::S_DETEND: begin
				if (det_q == 3'd0)
					state_d = (acc_q == '0) ? tca_pkg::S_IDLE : tca_pkg::S_DET;
				else
					state_d = tca_pkg::S_DIV;
			end
			tca_pkg::S_DIV: begin
				if (div_last)
					state_d = tca_pkg::S_STORE;
			end
			tca_pkg::S_STORE: begin
				state_d = (det_q == 3'(tca_pkg::NUM_DETS - 1)) ? tca_pkg::S_IDLE : tca_pkg::S_DET;
			end
			default: state_d = tca_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			tca_pkg::S_IDLE: begin
				req.ready = !out_valid_q;
			end
			tca_pkg::S_ADD: begin
				case (add_idx_q)
					3'd0: begin mul_a = 32'(tx_q); mul_b = 32'(tx_q); end
					3'd1: begin mul_a = 32'(tx_q); mul_b = 32'(ty_q); end
					3'd2: begin mul_a = 32'(ty_q); mul_b = 32'(ty_q); end
					3'd3: begin mul_a = 32'(sx_q); mul_b = 32'(tx_q); end
					3'd4: begin mul_a = 32'(sx_q); mul_b = 32'(ty_q); end
					3'd5: begin mul_a = 32'(sy_q); mul_b = 32'(tx_q); end
					default: begin mul_a = 32'(sy_q); mul_b = 32'(ty_q); end
				endcase
			end
			tca_pkg::S_DET: begin
				case (ph_q)
					2'd0: begin
						mul_a = tca_pkg::elem(sums_q, cnt_q, det_q, 2'd0, tca_pkg::TERM_C0[term_q]);
						mul_b = tca_pkg::elem(sums_q, cnt_q, det_q, 2'd1, tca_pkg::TERM_C1[term_q]);
					end
					2'd1: begin
						mul_a = prod_q[31:0];
						mul_b = tca_pkg::elem(sums_q, cnt_q, det_q, 2'd2, tca_pkg::TERM_C2[term_q]);
					end
					2'd2: begin
						mul_a = thi_q;
						mul_b = tca_pkg::elem(sums_q, cnt_q, det_q, 2'd2, tca_pkg::TERM_C2[term_q]);
					end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tca_pkg::S_IDLE;
			sums_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			add_idx_q <= '0;
			det_q <= '0;
			term_q <= '0;
			ph_q <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				tca_pkg::S_IDLE: begin
					if (accept) begin
						add_idx_q <= '0;
						det_q <= '0;
						term_q <= '0;
						ph_q <= '0;
						if (state_d == tca_pkg::S_IDLE)
							out_valid_q <= 1'b1;
						if (req.opcode == tca_pkg::OP_CLEAR) begin
							sums_q <= '0;
							cnt_q <= '0;
						end
					end
				end
				tca_pkg::S_ADD: begin
					sums_q.prd[add_idx_q] <= sums_q.prd[add_idx_q] + mul_p[31:0];
					add_idx_q <= add_idx_q + 3'd1;
					if (add_last) begin
						sums_q.lin[tca_pkg::LS_X] <= sums_q.lin[tca_pkg::LS_X] + 16'(tx_q);
						sums_q.lin[tca_pkg::LS_Y] <= sums_q.lin[tca_pkg::LS_Y] + 16'(ty_q);
						sums_q.lin[tca_pkg::LS_SX] <= sums_q.lin[tca_pkg::LS_SX] + 16'(sx_q);
						sums_q.lin[tca_pkg::LS_SY] <= sums_q.lin[tca_pkg::LS_SY] + 16'(sy_q);
						cnt_q <= cnt_q + 5'd1;
						out_valid_q <= 1'b1;
					end
				end
				tca_pkg::S_DET: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3)
						term_q <= (term_q == 3'(tca_pkg::NUM_TERMS - 1)) ? 3'd0 : term_q + 3'd1;
				end
				tca_pkg::S_DETEND: begin
					div_cnt_q <= '0;
					if (det_q == 3'd0) begin
						det_q <= 3'd1;
						if (acc_q == '0)
							out_valid_q <= 1'b1;
					end
				end
				tca_pkg::S_DIV: begin
					div_cnt_q <= div_cnt_q + 7'd1;
				end
				tca_pkg::S_STORE: begin
					det_q <= det_q + 3'd1;
					if (det_q == 3'(tca_pkg::NUM_DETS - 1))
						out_valid_q <= 1'b1;
				end
				default: begin end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tca_pkg::S_IDLE: begin
				if (accept) begin
					tx_q <= req.touch_x;
					ty_q <= req.touch_y;
					sx_q <= req.screen_x;
					sy_q <= req.screen_y;
					acc_q <= '0;
					for (int i = 0; i < tca_pkg::NUM_TERMS; i++)
						coef_q[i] <= '0;
					case (req.opcode)
						tca_pkg::OP_ADD: status_q <= (cnt_q < tca_pkg::CNT_W'(tca_pkg::MAX_POINTS))
							? tca_pkg::ST_DONE : tca_pkg::ST_FULL;
						tca_pkg::OP_SOLVE: status_q <= (cnt_q < tca_pkg::CNT_W'(tca_pkg::MIN_POINTS))
							? tca_pkg::ST_FEW : tca_pkg::ST_SOLVED;
						default: status_q <= tca_pkg::ST_DONE;
					endcase
				end
			end
			tca_pkg::S_DET: begin
				case (ph_q)
					2'd0: prod_q <= mul_p;
					2'd1: begin
						prod_q <= mul_p;
						thi_q <= prod_q[63:32];
					end
					2'd2: begin
						prod_q <= mul_p;
						acc_q <= neg_term ? acc_q - tca_pkg::ACC_W'(prod_q)
							: acc_q + tca_pkg::ACC_W'(prod_q);
					end
					default: begin
						acc_q <= neg_term ? acc_q - {4'd0, prod_q, 32'd0}
							: acc_q + {4'd0, prod_q, 32'd0};
					end
				endcase
			end
			tca_pkg::S_DETEND: begin
				rem_q <= '0;
				quo_q <= '0;
				dvd_q <= {acc_mag[95:0], 32'd0};
				nneg_q <= acc_q[tca_pkg::ACC_W-1];
				if (det_q == 3'd0) begin
					dmag_q <= acc_mag;
					dneg_q <= acc_q[tca_pkg::ACC_W-1];
					acc_q <= '0;
					if (acc_q == '0)
						status_q <= tca_pkg::ST_SINGULAR;
				end
			end
			tca_pkg::S_DIV: begin
				rem_q <= ge ? rsh - den : rsh;
				quo_q <= {quo_q[tca_pkg::DIV_W-2:0], ge};
				dvd_q <= {dvd_q[tca_pkg::DIV_W-2:0], 1'b0};
			end
			tca_pkg::S_STORE: begin
				coef_q[det_q - 3'd1] <= tca_pkg::sat_q32(quo_q, nneg_q != dneg_q);
				acc_q <= '0;
			end
			default: begin end
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.coef_a = coef_q[0];
	assign rsp.coef_b = coef_q[1];
	assign rsp.coef_c = coef_q[2];
	assign rsp.coef_d = coef_q[3];
	assign rsp.coef_e = coef_q[4];
	assign rsp.coef_f = coef_q[5];

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (state_q == tca_pkg::S_IDLE && !out_valid_q))
		else $error("ready raised while an item is in work");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> state_q == tca_pkg::S_IDLE)
		else $error("result shown while the sequencer is busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tca_pkg::CNT_W'(tca_pkg::MAX_POINTS))
		else $error("point count beyond the store size");

	a_zero_unless_solved: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != tca_pkg::ST_SOLVED) |->
		(rsp.coef_a == '0 && rsp.coef_c == '0 && rsp.coef_f == '0))
		else $error("coefficients not cleared for an unsolved result");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tca_pkg::S_ADD && add_last) |=> cnt_q == $past(cnt_q) + 5'd1)
		else $error("point count not advanced by an add");

endmodule
